// ===== design/scc_pkg.sv =====
package scc_pkg;

    localparam int STRIPS_DEFAULT     = 640;
    localparam int ASIC_WIDTH_DEFAULT = 64;
    localparam int QUEUE_DEPTH        = 4;
    localparam logic [7:0] NSIGMA_RESET = 8'd80;
    localparam int DIV_STEPS          = 16;

    localparam logic [24:0] ENERGY_MAX = 25'h1FFFFFF;
    localparam logic [35:0] WEIGHT_MAX = 36'hFFFFFFFFF;
    localparam logic [9:0]  COUNT_MAX  = 10'd1023;

    typedef struct packed {
        logic [35:0] weight;
        logic [24:0] energy;
        logic [9:0]  count;
        logic        last;
    } cluster_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } back_state_t;

endpackage

// ===== design/scc_front.sv =====
module scc_front #(
    parameter int STRIPS     = scc_pkg::STRIPS_DEFAULT,
    parameter int ASIC_WIDTH = scc_pkg::ASIC_WIDTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        nsigma,
    input  logic              take,
    input  logic [9:0]        strip_index,
    input  logic signed [15:0] strip_signal,
    input  logic [11:0]       noise_sigma,
    input  logic              strip_good,
    input  logic              end_of_event,
    output logic              push_a,
    output scc_pkg::cluster_t data_a,
    output logic              push_b,
    output scc_pkg::cluster_t data_b
);

    localparam int RECIP_SHIFT = 20;
    localparam int RECIP = (2 ** RECIP_SHIFT + ASIC_WIDTH - 1) / ASIC_WIDTH;

    logic        open_reg, open_next;
    logic [9:0]  last_reg, last_next;
    logic [24:0] energy_reg, energy_next;
    logic [35:0] weight_reg, weight_next;
    logic [9:0]  count_reg, count_next;

    logic [29:0] recip_mul;
    logic [9:0]  asic_q;
    logic [19:0] asic_qw;
    logic [9:0]  asic_m;
    logic [19:0] thr_prod;
    logic [19:0] sig_scaled;
    logic [14:0] sig_mag;
    logic [24:0] sig_w;
    logic        accept;
    logic        join_cl;
    logic [9:0]  gap;
    logic [25:0] energy_sum;
    logic [36:0] weight_sum;
    logic        open_mid;

    always_comb
    begin
        recip_mul  = 30'(strip_index) * 30'(RECIP);
        asic_q     = recip_mul[29:RECIP_SHIFT];
        asic_qw    = 20'(asic_q) * 20'(ASIC_WIDTH);
        asic_m     = strip_index - asic_qw[9:0];
        thr_prod   = 20'(nsigma) * 20'(noise_sigma);
        sig_mag    = strip_signal[14:0];
        sig_scaled = {1'b0, sig_mag, 4'b0000};
        sig_w      = 25'(sig_mag) * 25'(strip_index);
        accept = take && strip_good && (strip_index != 10'd0)
                 && (11'(strip_index) <= 11'(STRIPS))
                 && (asic_m >= 10'd4) && (11'(asic_m) <= 11'(ASIC_WIDTH - 3))
                 && !strip_signal[15] && (sig_scaled >= thr_prod);
        gap = (strip_index > last_reg) ? strip_index - last_reg : last_reg - strip_index;
        join_cl    = open_reg && (gap < 10'd2);
        energy_sum = 26'(energy_reg) + 26'(sig_mag);
        weight_sum = 37'(weight_reg) + 37'(sig_w);

        push_a      = accept && open_reg && !join_cl;
        data_a.weight = weight_reg;
        data_a.energy = energy_reg;
        data_a.count  = count_reg;
        data_a.last   = 1'b0;

        open_mid    = open_reg;
        last_next   = last_reg;
        energy_next = energy_reg;
        weight_next = weight_reg;
        count_next  = count_reg;
        if (accept)
        begin
            open_mid  = 1'b1;
            last_next = strip_index;
            if (join_cl)
            begin
                energy_next = energy_sum[25] ? scc_pkg::ENERGY_MAX : energy_sum[24:0];
                weight_next = weight_sum[36] ? scc_pkg::WEIGHT_MAX : weight_sum[35:0];
                count_next  = (count_reg < scc_pkg::COUNT_MAX) ? count_reg + 10'd1 : count_reg;
            end
            else
            begin
                energy_next = 25'(sig_mag);
                weight_next = 36'(sig_w);
                count_next  = 10'd1;
            end
        end

        push_b        = take && end_of_event && open_mid;
        data_b.weight = weight_next;
        data_b.energy = energy_next;
        data_b.count  = count_next;
        data_b.last   = 1'b1;

        open_next = open_mid;
        if (push_b)
        begin
            open_next   = 1'b0;
            last_next   = 10'd0;
            energy_next = 25'd0;
            weight_next = 36'd0;
            count_next  = 10'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            last_reg   <= 10'd0;
            energy_reg <= 25'd0;
            weight_reg <= 36'd0;
            count_reg  <= 10'd0;
        end
        else
        begin
            open_reg   <= open_next;
            last_reg   <= last_next;
            energy_reg <= energy_next;
            weight_reg <= weight_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/scc_fifo.sv =====
module scc_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_a,
    input  scc_pkg::cluster_t data_a,
    input  logic              push_b,
    input  scc_pkg::cluster_t data_b,
    output logic              room2,
    output logic              not_empty,
    input  logic              pop,
    output scc_pkg::cluster_t head
);

    localparam int PW = $clog2(scc_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(scc_pkg::QUEUE_DEPTH + 1);

    scc_pkg::cluster_t mem [scc_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] wr_b;

    always_comb
    begin
        wr_b      = push_a ? wr_reg + PW'(1) : wr_reg;
        wr_next   = wr_reg + PW'(push_a) + PW'(push_b);
        rd_next   = pop ? rd_reg + PW'(1) : rd_reg;
        cnt_next  = cnt_reg + CW'(push_a) + CW'(push_b) - CW'(pop);
        room2     = cnt_reg <= CW'(scc_pkg::QUEUE_DEPTH - 2);
        not_empty = cnt_reg != CW'(0);
        head      = mem[rd_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            mem[wr_reg] <= data_a;
        end
        if (push_b)
        begin
            mem[wr_b] <= data_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== design/scc_back.sv =====
module scc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              not_empty,
    input  scc_pkg::cluster_t head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       centroid,
    output logic [24:0]       energy_total,
    output logic [9:0]        multiplicity,
    output logic              zero_sum,
    output logic              last_of_event
);

    scc_pkg::back_state_t state_reg, state_next;
    logic [3:0]  step_reg;
    logic [42:0] rem_reg;
    logic [42:0] div_reg;
    logic [15:0] quo_reg;
    logic        ovf_reg, zero_reg;
    scc_pkg::cluster_t cl_reg;
    logic        valid_reg;
    logic        load_out;
    logic [42:0] num;
    logic [42:0] lim;
    logic        fits;

    always_comb
    begin
        num  = {1'b0, head.weight, 6'b000000} + 43'(head.energy[24:1]);
        lim  = {2'b00, head.energy, 16'h0000};
        fits = rem_reg >= div_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scc_pkg::S_IDLE: if (not_empty) state_next = scc_pkg::S_DIV;
            scc_pkg::S_DIV:  if (step_reg == 4'd0) state_next = scc_pkg::S_DONE;
            scc_pkg::S_DONE: if (!valid_reg || out_ready) state_next = scc_pkg::S_IDLE;
            default:         state_next = scc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            scc_pkg::S_IDLE: pop = not_empty;
            scc_pkg::S_DONE: load_out = !valid_reg || out_ready;
            default:         pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cl_reg   <= head;
            rem_reg  <= num;
            div_reg  <= {3'b000, head.energy, 15'h0000};
            quo_reg  <= 16'h0000;
            ovf_reg  <= num >= lim;
            zero_reg <= head.energy == 25'd0;
        end
        else if (state_reg == scc_pkg::S_DIV)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - div_reg;
            end
            div_reg <= div_reg >> 1;
            quo_reg <= {quo_reg[14:0], fits};
        end
        if (load_out)
        begin
            centroid      <= zero_reg ? 16'h0000 : (ovf_reg ? 16'hFFFF : quo_reg);
            energy_total  <= cl_reg.energy;
            multiplicity  <= cl_reg.count;
            zero_sum      <= zero_reg;
            last_of_event <= cl_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scc_pkg::S_IDLE;
            step_reg  <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                step_reg <= 4'(scc_pkg::DIV_STEPS - 1);
            end
            else if (state_reg == scc_pkg::S_DIV)
            begin
                step_reg <= step_reg - 4'd1;
            end
            if (load_out)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = valid_reg;

    a_zero_centroid: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && zero_sum |-> centroid == 16'h0000)
        else $error("zero-sum cluster with non-zero centroid");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == scc_pkg::S_IDLE && not_empty)
        else $error("queue popped outside idle");
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == scc_pkg::S_DIV && step_reg == 4'd0 |=> state_reg == scc_pkg::S_DONE)
        else $error("divider did not finish");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !valid_reg || out_ready)
        else $error("output overwritten while stalled");

endmodule

// ===== design/strip_cluster_centroid.sv =====
// Strip cluster finder with centre-of-gravity output.
// One strip word enters per cycle on in_valid/in_ready while in_ready is high;
// cut strips and strips that join the open cluster are taken at that rate too.
// When a cluster closes, or an event ends, its sums go into a four-entry queue,
// and in_ready drops while fewer than two entries are free.
// The back end takes one queued cluster at a time and divides the weighted sum
// by the energy sum in a restoring divider, one quotient bit per cycle; it pops
// the next cluster only once the last result has entered the output register.
// Results leave on out_valid/out_ready from an output register; while the
// receiver stalls, the divider finishes the next cluster and waits, and the
// front end keeps accepting strips until fewer than two queue entries are free.
// nsigma is written through cfg_valid/cfg_data, always ready; the user must
// write it only while idle, which the block does not enforce. Reset empties the
// queue, closes any open cluster and sets nsigma to 5.0.
module strip_cluster_centroid #(
    parameter int STRIPS     = scc_pkg::STRIPS_DEFAULT,
    parameter int ASIC_WIDTH = scc_pkg::ASIC_WIDTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [9:0]         strip_index,
    input  logic signed [15:0] strip_signal,
    input  logic [11:0]        noise_sigma,
    input  logic               strip_good,
    input  logic               end_of_event,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        centroid,
    output logic [24:0]        energy_total,
    output logic [9:0]         multiplicity,
    output logic               zero_sum,
    output logic               last_of_event
);

    logic [7:0] nsigma_reg;
    logic push_a, push_b, room2, not_empty, pop;
    scc_pkg::cluster_t data_a, data_b, head;

    assign cfg_ready = 1'b1;
    assign in_ready  = room2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nsigma_reg <= scc_pkg::NSIGMA_RESET;
        end
        else if (cfg_valid)
        begin
            nsigma_reg <= cfg_data;
        end
    end

    scc_front #(.STRIPS(STRIPS), .ASIC_WIDTH(ASIC_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .nsigma(nsigma_reg), .take(in_valid && room2),
        .strip_index(strip_index), .strip_signal(strip_signal),
        .noise_sigma(noise_sigma), .strip_good(strip_good),
        .end_of_event(end_of_event), .push_a(push_a), .data_a(data_a),
        .push_b(push_b), .data_b(data_b)
    );

    scc_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .push_a(push_a), .data_a(data_a),
        .push_b(push_b), .data_b(data_b), .room2(room2),
        .not_empty(not_empty), .pop(pop), .head(head)
    );

    scc_back u_back (
        .clk(clk), .rst_n(rst_n), .not_empty(not_empty), .head(head), .pop(pop),
        .out_valid(out_valid), .out_ready(out_ready), .centroid(centroid),
        .energy_total(energy_total), .multiplicity(multiplicity),
        .zero_sum(zero_sum), .last_of_event(last_of_event)
    );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STRIPS     = 640;
    localparam int ASIC_WIDTH = 64;

    typedef struct {
        logic [9:0]         idx;
        logic signed [15:0] sig;
        logic [11:0]        sigma;
        logic               good;
        logic               eoe;
    } strip_t;

    typedef struct {
        logic [15:0] centroid;
        logic [24:0] energy;
        logic [9:0]  mult;
        logic        zero;
        logic        last;
    } cluster_word_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [7:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [9:0]         strip_index;
    logic signed [15:0] strip_signal;
    logic [11:0]        noise_sigma;
    logic               strip_good;
    logic               end_of_event;
    logic               out_valid;
    logic               out_ready;
    logic [15:0]        centroid;
    logic [24:0]        energy_total;
    logic [9:0]         multiplicity;
    logic               zero_sum;
    logic               last_of_event;

    strip_t        strip_queue[$];
    cluster_word_t cluster_queue[$];
    int            errors;
    int            cycle_count;
    int            words_seen;
    int            hold_left;
    logic          hold_done;

    // Predictor state.
    logic [7:0]  nsigma_now;
    logic        open_now;
    logic [9:0]  last_idx;
    logic [24:0] energy_acc;
    logic [35:0] weight_acc;
    logic [9:0]  count_acc;

    strip_cluster_centroid #(.STRIPS(STRIPS), .ASIC_WIDTH(ASIC_WIDTH)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .strip_index(strip_index), .strip_signal(strip_signal),
        .noise_sigma(noise_sigma), .strip_good(strip_good),
        .end_of_event(end_of_event),
        .out_valid(out_valid), .out_ready(out_ready),
        .centroid(centroid), .energy_total(energy_total),
        .multiplicity(multiplicity), .zero_sum(zero_sum),
        .last_of_event(last_of_event)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic cluster_word_t close_cluster(input logic last);
        cluster_word_t w;
        logic [63:0]   q;
        w.zero = (energy_acc == 25'd0);
        q = '0;
        if (!w.zero)
        begin
            q = ({28'd0, weight_acc} * 64 + {39'd0, energy_acc} / 2) / {39'd0, energy_acc};
            if (q > 64'hFFFF)
                q = 64'hFFFF;
        end
        w.centroid = q[15:0];
        w.energy   = energy_acc;
        w.mult     = count_acc;
        w.last     = last;
        return w;
    endfunction

    task automatic predict_clusters(input strip_t s);
        logic [9:0]  m;
        logic        pass;
        logic [63:0] e;
        logic [63:0] wsum;
        int          d;
        m = 10'(s.idx % ASIC_WIDTH);
        pass = s.good && s.idx != 0 && s.idx <= STRIPS && m >= 4 && m <= ASIC_WIDTH - 3
               && (64'(s.sig) * 16 >= $signed({56'd0, nsigma_now}) * $signed({52'd0, s.sigma}));
        if (pass)
        begin
            d = int'(s.idx) - int'(last_idx);
            if (open_now && (d < 2 && d > -2))
            begin
                last_idx = s.idx;
                e = {39'd0, energy_acc} + {48'd0, s.sig};
                energy_acc = (e > scc_pkg::ENERGY_MAX) ? scc_pkg::ENERGY_MAX : e[24:0];
                wsum = {28'd0, weight_acc} + {48'd0, s.sig} * s.idx;
                weight_acc = (wsum > scc_pkg::WEIGHT_MAX) ? scc_pkg::WEIGHT_MAX : wsum[35:0];
                if (count_acc < scc_pkg::COUNT_MAX)
                    count_acc = count_acc + 10'd1;
            end
            else
            begin
                if (open_now)
                    cluster_queue.insert(cluster_queue.size(), close_cluster(1'b0));
                open_now   = 1'b1;
                last_idx   = s.idx;
                energy_acc = {9'd0, s.sig};
                weight_acc = {20'd0, s.sig} * s.idx;
                count_acc  = 10'd1;
            end
        end
        if (s.eoe && open_now)
        begin
            cluster_queue.insert(cluster_queue.size(), close_cluster(1'b1));
            open_now   = 1'b0;
            last_idx   = '0;
            energy_acc = '0;
            weight_acc = '0;
            count_acc  = '0;
        end
    endtask

    // Sender: no idling during one long stretch of the run.
    always @(posedge clk or negedge rst_n)
    begin
        strip_t s;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            strip_index  <= '0;
            strip_signal <= '0;
            noise_sigma  <= '0;
            strip_good   <= 1'b0;
            end_of_event <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                s.idx = strip_index;
                s.sig = strip_signal;
                s.sigma = noise_sigma;
                s.good = strip_good;
                s.eoe = end_of_event;
                predict_clusters(s);
            end
            if (!in_valid || in_ready)
            begin
                if (strip_queue.size() > 0 && ((cycle_count > 3000 && cycle_count < 6000)
                    || $urandom_range(0, 99) >= 25))
                begin
                    s = strip_queue.pop_front();
                    strip_index  <= s.idx;
                    strip_signal <= s.sig;
                    noise_sigma  <= s.sigma;
                    strip_good   <= s.good;
                    end_of_event <= s.eoe;
                    in_valid     <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold-off, and a calm stretch.
    always @(posedge clk or negedge rst_n)
    begin
        cluster_word_t w;
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            cycle_count <= 0;
            words_seen  <= 0;
            hold_left   <= 0;
            hold_done   <= 1'b0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (out_valid && out_ready)
            begin
                words_seen <= words_seen + 1;
                if (cluster_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: expected no word, actual %h %h %h %b %b", $time,
                             centroid, energy_total, multiplicity, zero_sum, last_of_event);
                end
                else
                begin
                    w = cluster_queue.pop_front();
                    if (w.centroid !== centroid || w.energy !== energy_total
                        || w.mult !== multiplicity || w.zero !== zero_sum
                        || w.last !== last_of_event)
                    begin
                        errors++;
                        $display("%0t: expected %h %h %h %b %b, actual %h %h %h %b %b",
                                 $time, w.centroid, w.energy, w.mult, w.zero, w.last,
                                 centroid, energy_total, multiplicity, zero_sum,
                                 last_of_event);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (!hold_done && words_seen >= 40)
            begin
                hold_done <= 1'b1;
                hold_left <= 600;
                out_ready <= 1'b0;
            end
            else
                out_ready <= (cycle_count > 3000 && cycle_count < 6000)
                             || $urandom_range(0, 99) >= 25;
        end
    end

    function automatic strip_t good_strip(input logic [9:0] idx, input logic eoe);
        strip_t s;
        int     lim;
        int     thr;
        lim = (nsigma_now == 0) ? 4095 : (32767 * 16) / nsigma_now;
        if (lim > 400)
            lim = 400;
        s.sigma = 12'($urandom_range(0, lim));
        thr = (nsigma_now * s.sigma + 15) / 16;
        thr = thr + $urandom_range(0, 2000);
        s.sig  = (thr > 32767) ? 16'sd32767 : 16'(thr);
        s.idx  = idx;
        s.good = 1'b1;
        s.eoe  = eoe;
        return s;
    endfunction

    function automatic strip_t noise_strip();
        strip_t s;
        s.idx   = 10'($urandom_range(0, 1023));
        s.sig   = 16'($urandom_range(0, 65535));
        s.sigma = 12'($urandom_range(0, 4095));
        s.good  = 1'($urandom_range(0, 1));
        s.eoe   = ($urandom_range(0, 9) == 0);
        return s;
    endfunction

    task automatic add_strip(input logic [9:0] idx, input logic signed [15:0] sig,
                             input logic [11:0] sigma, input logic good, input logic eoe);
        strip_t s;
        s.idx = idx;
        s.sig = sig;
        s.sigma = sigma;
        s.good = good;
        s.eoe = eoe;
        strip_queue.insert(strip_queue.size(), s);
    endtask

    task automatic random_events(input int items);
        int          n;
        int          k;
        int          len;
        logic [9:0]  idx;
        strip_t      s;
        n = 0;
        while (n < items)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                strip_queue.insert(strip_queue.size(), noise_strip());
                n++;
            end
            else
            begin
                for (k = $urandom_range(1, 4); k > 0; k--)
                begin
                    idx = 10'($urandom_range(0, 9) * 64 + $urandom_range(4, 61));
                    for (len = $urandom_range(1, 4); len > 0; len--)
                    begin
                        if ($urandom_range(0, 9) == 0)
                        begin
                            s = noise_strip();
                            s.eoe = 1'b0;
                            strip_queue.insert(strip_queue.size(), s);
                            n++;
                        end
                        strip_queue.insert(strip_queue.size(),
                                           good_strip(idx, k == 1 && len == 1));
                        n++;
                        idx = 10'(idx + $urandom_range(0, 9) / 4);
                    end
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (strip_queue.size() > 0 || in_valid || cluster_queue.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_nsigma(input logic [7:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        nsigma_now = value;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int k;
        errors     = 0;
        nsigma_now = scc_pkg::NSIGMA_RESET;
        open_now   = 1'b0;
        last_idx   = '0;
        energy_acc = '0;
        weight_acc = '0;
        count_acc  = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: borders, out-of-range indices, threshold edge, zero sum,
        // close and flush together, end of event with nothing open.
        add_strip(10'd3, 16'sd1000, 12'd1, 1'b1, 1'b0);
        add_strip(10'd62, 16'sd1000, 12'd1, 1'b1, 1'b0);
        add_strip(10'd0, 16'sd1000, 12'd1, 1'b1, 1'b0);
        add_strip(10'd1023, 16'sd1000, 12'd1, 1'b1, 1'b0);
        add_strip(10'd700, 16'sd1000, 12'd1, 1'b1, 1'b1);
        add_strip(10'd10, 16'sd1000, 12'd1, 1'b0, 1'b1);
        add_strip(10'd4, 16'sd25, 12'd5, 1'b1, 1'b0);
        add_strip(10'd5, 16'sd24, 12'd5, 1'b1, 1'b0);
        add_strip(10'd5, 16'sd32767, 12'd0, 1'b1, 1'b0);
        add_strip(10'd61, 16'sh8000, 12'd4095, 1'b1, 1'b1);
        add_strip(10'd20, 16'sd0, 12'd0, 1'b1, 1'b0);
        add_strip(10'd21, 16'sd0, 12'd0, 1'b1, 1'b1);
        add_strip(10'd100, 16'sd500, 12'd10, 1'b1, 1'b0);
        add_strip(10'd101, 16'sd700, 12'd10, 1'b1, 1'b0);
        add_strip(10'd200, 16'sd900, 12'd10, 1'b1, 1'b1);
        add_strip(10'd637, 16'sd300, 12'd2, 1'b1, 1'b1);
        add_strip(10'd580, 16'sd300, 12'd2, 1'b1, 1'b0);
        add_strip(10'd580, 16'sd300, 12'd2, 1'b1, 1'b0);
        add_strip(10'd582, 16'sd300, 12'd2, 1'b1, 1'b1);
        random_events(150);
        wait_drained();

        write_nsigma(8'd0);
        random_events(150);
        wait_drained();

        // One long cluster that saturates the energy sum and the count.
        write_nsigma(8'd255);
        for (k = 0; k < 1030; k++)
            add_strip(10'd600, 16'sd32767, 12'd0, 1'b1, k == 1029);
        random_events(100);
        wait_drained();

        write_nsigma(8'($urandom_range(1, 254)));
        random_events(150);
        wait_drained();

        write_nsigma(scc_pkg::NSIGMA_RESET);
        random_events(150);
        wait_drained();

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== strip_cluster_centroid.f =====
design/scc_pkg.sv
design/scc_front.sv
design/scc_fifo.sv
design/scc_back.sv
design/strip_cluster_centroid.sv
tb/tb_top.sv
